FILE: rtl/xyz_to_display_rgb_assert.svh
// Assertion macros shared by the XYZ to display RGB converter.
`ifndef XYZ_TO_DISPLAY_RGB_ASSERT_SVH
`define XYZ_TO_DISPLAY_RGB_ASSERT_SVH

// Property that must hold in the same cycle as its condition.
`define XDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after its condition.
`define XDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/xdr_pkg.sv
// Shared types and constants of the XYZ to display RGB converter.
package xdr_pkg;

  // Field widths and fixed-point positions.
  localparam int LUM_W     = 20;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = 14;
  localparam int SCALE_W   = 24;
  localparam int SCALE_SH  = 24;
  localparam int PIX_W     = 8;
  localparam int NUM_CH    = 3;
  localparam int NUM_COEF  = 9;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_CONVERT = 2'd0,
    REQ_TABLE   = 2'd1,
    REQ_COEF    = 2'd2,
    REQ_UNUSED  = 2'd3
  } xdr_req_e;

  // Channel codes of a table write.
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_NONE  = 2'd3
  } xdr_ch_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_FLOOR_R = 3'd0,
    REG_FLOOR_G = 3'd1,
    REG_FLOOR_B = 3'd2,
    REG_SCALE_R = 3'd3,
    REG_SCALE_G = 3'd4,
    REG_SCALE_B = 3'd5,
    REG_WHITE   = 3'd6
  } xdr_reg_e;

  // Control word that travels with each pipeline slot.
  typedef struct packed {
    logic valid;
    logic conv;
    logic twr;
  } xdr_ctl_t;

  // Port controls of one lookup table.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } xdr_lut_ctl_t;

endpackage

FILE: rtl/xdr_lane.sv
// One color lane: matrix row product, luminance clip, scaling and table index.
module xdr_lane #(
  parameter int LAST_INDEX = 1500,
  parameter int AW = $clog2(LAST_INDEX + 1)
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [xdr_pkg::LUM_W-1:0] x_i,
  input  logic signed [xdr_pkg::LUM_W-1:0] y_i,
  input  logic signed [xdr_pkg::LUM_W-1:0] z_i,
  input  logic [2:0][xdr_pkg::COEF_W-1:0]  coef_i,
  input  logic signed [xdr_pkg::LUM_W-1:0] floor_i,
  input  logic [xdr_pkg::SCALE_W-1:0]     scale_i,
  output logic [AW-1:0]                   idx_o
);
  import xdr_pkg::*;

  localparam int PROD_W  = COEF_W + LUM_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SPROD_W = LUM_W + SCALE_W;
  localparam int TOP_LO  = COEF_FRAC + LUM_W - 1;

  logic signed [PROD_W-1:0]  prod_d [3];
  logic signed [PROD_W-1:0]  prod_q [3];
  logic signed [ACC_W-1:0]   acc;
  logic signed [LUM_W-1:0]   lum_d, lum_q;
  logic signed [LUM_W-1:0]   lum_cl;
  logic signed [LUM_W:0]     diff_full;
  logic [LUM_W-1:0]          diff_d, diff_q;
  logic [SPROD_W-1:0]        sprod_d, sprod_q;
  logic [LUM_W-1:0]          quot;

  // Three products of the coefficient row with the pixel.
  always_comb begin
    prod_d[0] = $signed(coef_i[0]) * x_i;
    prod_d[1] = $signed(coef_i[1]) * y_i;
    prod_d[2] = $signed(coef_i[2]) * z_i;
  end

  // Sum, floor shift to Q12.8 and saturation to the luminance range.
  always_comb begin
    acc = ACC_W'(prod_q[0]) + ACC_W'(prod_q[1]) + ACC_W'(prod_q[2]);
    if (acc[ACC_W-1:TOP_LO] == {(ACC_W - TOP_LO){acc[ACC_W-1]}}) begin
      lum_d = acc[TOP_LO:COEF_FRAC];
    end else if (acc[ACC_W-1]) begin
      lum_d = {1'b1, {(LUM_W - 1){1'b0}}};
    end else begin
      lum_d = {1'b0, {(LUM_W - 1){1'b1}}};
    end
  end

  // Clip at the floor and take the distance above it.
  always_comb begin
    lum_cl    = (lum_q < floor_i) ? floor_i : lum_q;
    diff_full = (LUM_W + 1)'(lum_cl) - (LUM_W + 1)'(floor_i);
    diff_d    = diff_full[LUM_W-1:0];
  end

  // Scale the distance into table steps.
  assign sprod_d = SPROD_W'(diff_q) * SPROD_W'(scale_i);

  // Integer part of the scaled value, saturated at the last entry.
  always_comb begin
    quot = sprod_q[SPROD_W-1:SCALE_SH];
    if (quot > LUM_W'(LAST_INDEX)) begin
      idx_o = AW'(LAST_INDEX);
    end else begin
      idx_o = AW'(quot);
    end
  end

  // Lane pipeline registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= prod_d;
      lum_q   <= lum_d;
      diff_q  <= diff_d;
      sprod_q <= sprod_d;
    end
  end

endmodule

FILE: rtl/xdr_lut.sv
// Per-channel 8-bit lookup table memory with one write and one registered read port.
module xdr_lut #(
  parameter int DEPTH = 1501,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  xdr_pkg::xdr_lut_ctl_t     ctl_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [xdr_pkg::PIX_W-1:0] wdata_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [xdr_pkg::PIX_W-1:0] rdata_o
);
  import xdr_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  // Table write and registered read.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/xyz_to_display_rgb.sv
// Top level of the XYZ to display RGB converter: request pipeline, registers, lanes, merge.
//
// Converts one CIE XYZ pixel per request into display RGB. The block takes one
// request every clock cycle while the output does not stall, and returns a
// pixel's result through the lane pipeline (input register, products,
// luminance sum, floor clip, scaling multiply, table read, output register).
// Three identical lanes, one per color, run side by side and the output stage
// merges their table bytes with the white limits. Coefficient writes take
// effect for the very next pixel; table writes travel down the pipeline and
// reach the tables in request order. The tables have no reset and no clearing
// pass, so every entry a pixel may hit must be written first. A stall on the
// output while a finished pixel is held stops the whole pipeline in the same cycle.
module xyz_to_display_rgb #(
  parameter int LAST_INDEX = 1500
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel and write requests.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic signed [19:0] x_value_i,
  input  logic signed [19:0] y_value_i,
  input  logic signed [19:0] z_value_i,
  input  logic        line_end_i,
  input  logic [10:0] write_index_i,
  input  logic [1:0]  write_channel_i,
  input  logic signed [17:0] write_data_i,
  // Converted pixels.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        line_end_out_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xdr_pkg::*;

  `include "xyz_to_display_rgb_assert.svh"

  localparam int AW     = $clog2(LAST_INDEX + 1);
  localparam int IW     = 11;
  localparam int STAGES = 6;
  localparam int WSTAGE = 5;

  logic                    pipe_en;
  logic                    in_accept;
  logic                    cfg_wr;
  xdr_reg_e                cfg_idx;

  logic [2:0][LUM_W-1:0]   floor_q;
  logic [2:0][SCALE_W-1:0] scale_q;
  logic [SCALE_W-1:0]      white_q;
  logic [NUM_COEF-1:0][COEF_W-1:0] coef_q;

  xdr_ctl_t                ctl_q [1:STAGES];
  logic                    le_q  [1:STAGES];
  logic [IW-1:0]           widx_q [1:WSTAGE];
  logic [1:0]              wch_q  [1:WSTAGE];
  logic [PIX_W-1:0]        wbyte_q [1:WSTAGE];
  logic signed [LUM_W-1:0] x_q, y_q, z_q;

  logic [AW-1:0]           idx   [NUM_CH];
  logic [PIX_W-1:0]        rdata [NUM_CH];
  xdr_lut_ctl_t            lut_ctl [NUM_CH];

  logic                    out_valid_q;
  logic [PIX_W-1:0]        red_q, green_q, blue_q;
  logic                    le_out_q;
  xdr_ctl_t                ctl_in;

  // Handshake: the pipeline moves unless a finished pixel is held.
  assign pipe_en    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !pipe_en;
  assign in_accept  = in_valid_i && pipe_en;

  // Decode the incoming request; unusable table writes become bubbles.
  always_comb begin
    ctl_in.valid = in_valid_i;
    ctl_in.conv  = in_valid_i && (xdr_req_e'(req_type_i) == REQ_CONVERT);
    ctl_in.twr   = in_valid_i && (xdr_req_e'(req_type_i) == REQ_TABLE)
                   && (32'(write_index_i) <= LAST_INDEX)
                   && (xdr_ch_e'(write_channel_i) != CH_NONE);
  end

  // Configuration writes.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = xdr_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= '0;
      scale_q <= {3{SCALE_W'(983040)}};
      white_q <= '1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FLOOR_R: floor_q[0] <= pwdata[LUM_W-1:0];
        REG_FLOOR_G: floor_q[1] <= pwdata[LUM_W-1:0];
        REG_FLOOR_B: floor_q[2] <= pwdata[LUM_W-1:0];
        REG_SCALE_R: scale_q[0] <= pwdata[SCALE_W-1:0];
        REG_SCALE_G: scale_q[1] <= pwdata[SCALE_W-1:0];
        REG_SCALE_B: scale_q[2] <= pwdata[SCALE_W-1:0];
        REG_WHITE:   white_q    <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      REG_FLOOR_R: prdata = {{(32 - LUM_W){floor_q[0][LUM_W-1]}}, floor_q[0]};
      REG_FLOOR_G: prdata = {{(32 - LUM_W){floor_q[1][LUM_W-1]}}, floor_q[1]};
      REG_FLOOR_B: prdata = {{(32 - LUM_W){floor_q[2][LUM_W-1]}}, floor_q[2]};
      REG_SCALE_R: prdata = 32'(scale_q[0]);
      REG_SCALE_G: prdata = 32'(scale_q[1]);
      REG_SCALE_B: prdata = 32'(scale_q[2]);
      REG_WHITE:   prdata = 32'(white_q);
      default:     prdata = '0;
    endcase
  end

  // Coefficient store, written as soon as the request is taken.
  always_ff @(posedge clk_i) begin
    if (in_accept && (xdr_req_e'(req_type_i) == REQ_COEF)
        && (write_index_i < IW'(NUM_COEF))) begin
      coef_q[write_index_i[3:0]] <= write_data_i;
    end
  end

  // Control pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 1; s <= STAGES; s++) begin
        ctl_q[s] <= '0;
      end
    end else if (pipe_en) begin
      ctl_q[1] <= ctl_in;
      for (int s = 2; s <= STAGES; s++) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  // Payload pipeline: pixel, line marker and table write fields.
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      x_q        <= x_value_i;
      y_q        <= y_value_i;
      z_q        <= z_value_i;
      le_q[1]    <= line_end_i;
      widx_q[1]  <= write_index_i;
      wch_q[1]   <= write_channel_i;
      wbyte_q[1] <= write_data_i[PIX_W-1:0];
      for (int s = 2; s <= STAGES; s++) begin
        le_q[s] <= le_q[s-1];
      end
      for (int s = 2; s <= WSTAGE; s++) begin
        widx_q[s]  <= widx_q[s-1];
        wch_q[s]   <= wch_q[s-1];
        wbyte_q[s] <= wbyte_q[s-1];
      end
    end
  end

  // One lane and one table per color.
  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    xdr_lane #(
      .LAST_INDEX (LAST_INDEX),
      .AW         (AW)
    ) u_lane (
      .clk_i   (clk_i),
      .en_i    (pipe_en),
      .x_i     (x_q),
      .y_i     (y_q),
      .z_i     (z_q),
      .coef_i  (coef_q[c*3 +: 3]),
      .floor_i (floor_q[c]),
      .scale_i (scale_q[c]),
      .idx_o   (idx[c])
    );

    always_comb begin
      lut_ctl[c].wr_en = pipe_en && ctl_q[WSTAGE].twr && (wch_q[WSTAGE] == 2'(c));
      lut_ctl[c].rd_en = pipe_en && ctl_q[WSTAGE].conv;
    end

    xdr_lut #(
      .DEPTH (LAST_INDEX + 1),
      .AW    (AW)
    ) u_lut (
      .clk_i   (clk_i),
      .ctl_i   (lut_ctl[c]),
      .waddr_i (AW'(widx_q[WSTAGE])),
      .wdata_i (wbyte_q[WSTAGE]),
      .raddr_i (idx[c]),
      .rdata_o (rdata[c])
    );
  end

  // Merge stage: white limits and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= ctl_q[STAGES].conv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      red_q    <= (rdata[0] < white_q[7:0])   ? rdata[0] : white_q[7:0];
      green_q  <= (rdata[1] < white_q[15:8])  ? rdata[1] : white_q[15:8];
      blue_q   <= (rdata[2] < white_q[23:16]) ? rdata[2] : white_q[23:16];
      le_out_q <= le_q[STAGES];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;
  assign line_end_out_o = le_out_q;

  // Checks on the pipeline control.
  `XDR_ASSERT_NEXT(a_stall_holds_last, !pipe_en, $stable(ctl_q[STAGES]), "stage moved in stall")
  `XDR_ASSERT_NEXT(a_coef_quiet, !(in_accept && (req_type_i == REQ_COEF)), $stable(coef_q),
                   "coefficient changed without a request")
  `XDR_ASSERT_NEXT(a_result_made, pipe_en && ctl_q[STAGES].conv, out_valid_q,
                   "converted pixel lost")
  `XDR_ASSERT_NOW(a_lut_port_single, 1'b1, $onehot0({ctl_q[WSTAGE].conv, ctl_q[WSTAGE].twr}),
                  "table read and write in one slot")

endmodule
